FILE: hdl/stb_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stb_pkg
// Shared types and constants of the scrolling text terminal buffer.
// ---------------------------------------------------------------------------
package stb_pkg;

    localparam int LINE_COUNT = 10;
    localparam int LINE_WIDTH = 32;

    localparam int ROW_W  = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int LEN_W  = $clog2(LINE_WIDTH + 1);
    localparam int DEPTH  = LINE_COUNT * LINE_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_LOW   = 8'd32;
    localparam logic [7:0] CH_HIGH  = 8'd126;
    localparam logic [6:0] CH_SPACE = 7'd32;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;   // take the item presented at the input
        logic load;   // load the result register
    } t_ctl_cmd;

    // Advance a physical row index around the ring
    function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] row);
        logic [ROW_W-1:0] res;
        if (row == ROW_W'(LINE_COUNT - 1)) begin
            res = '0;
        end else begin
            res = row + 1'b1;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/stb_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stb_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: hdl/stb_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stb_ctrl
// Controller: takes one item, waits for the memory read, loads the result.
// ---------------------------------------------------------------------------
module stb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output stb_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;

    logic w_exec;
    logic w_load;

    assign w_exec = i_in_valid && !r_in_stall;
    assign w_load = (r_state == S_LOOK) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_exec) begin
                        r_state    <= S_LOOK;
                        r_in_stall <= 1'b1;
                    end
                end
                S_LOOK: begin
                    if (w_load) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_stall <= 1'b0;
                end
            endcase
            // drop valid once the result is taken, set it on a load
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd.exec  = w_exec;
    assign o_cmd.load  = w_load;
    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: hdl/stb_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stb_datapath
// Cursor, scroll pointer, row lengths, character store and result register.
// ---------------------------------------------------------------------------
module stb_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stb_pkg::t_ctl_cmd i_cmd,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_char_code,
    input  logic [3:0]        i_read_row,
    input  logic [4:0]        i_read_col,
    output logic [6:0]        o_cell_char,
    output logic [3:0]        o_cursor_row,
    output logic [5:0]        o_cursor_col
);

    localparam int ROW_W  = stb_pkg::ROW_W;
    localparam int LEN_W  = stb_pkg::LEN_W;
    localparam int ADDR_W = stb_pkg::ADDR_W;

    logic [ROW_W-1:0] r_top, n_top;
    logic [ROW_W-1:0] r_line, n_line;
    logic [ROW_W-1:0] r_cur_phys, n_cur_phys;
    logic [LEN_W-1:0] r_col, n_col;
    logic [LEN_W-1:0] r_len [stb_pkg::LINE_COUNT];
    logic             r_hit, n_hit;

    logic [6:0]       r_cell_char;
    logic [3:0]       r_cursor_row;
    logic [5:0]       r_cursor_col;

    logic             w_is_cr, w_is_lf, w_is_print, w_wrap;
    logic [6:0]       w_glyph;
    logic [LEN_W-1:0] w_col_pos;
    logic             w_len_we, w_clear_all;
    logic [LEN_W-1:0] w_len_wdata;
    logic             w_ram_we, w_ram_re;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [6:0]       w_ram_q;

    logic             w_rd_in_range, w_rd_hit;
    logic [ROW_W:0]   w_rd_sum;
    logic [ROW_W-1:0] w_rd_phys;
    logic [LEN_W-1:0] w_rd_len;

    assign w_is_cr    = (i_char_code == stb_pkg::CH_CR);
    assign w_is_lf    = (i_char_code == stb_pkg::CH_LF);
    assign w_is_print = (i_char_code >= stb_pkg::CH_LOW) && (i_char_code <= stb_pkg::CH_HIGH);
    assign w_glyph    = w_is_print ? i_char_code[6:0] : stb_pkg::CH_SPACE;
    assign w_wrap     = (r_col == LEN_W'(stb_pkg::LINE_WIDTH));

    // read side: visible row to physical row, then length check
    assign w_rd_in_range = 32'(i_read_row) < 32'(stb_pkg::LINE_COUNT);
    assign w_rd_sum      = (ROW_W+1)'(r_top) + (ROW_W+1)'(i_read_row);
    assign w_rd_phys     = (w_rd_sum >= (ROW_W+1)'(stb_pkg::LINE_COUNT))
                         ? ROW_W'(w_rd_sum - (ROW_W+1)'(stb_pkg::LINE_COUNT))
                         : ROW_W'(w_rd_sum);
    assign w_rd_len      = w_rd_in_range ? r_len[w_rd_phys] : '0;
    assign w_rd_hit      = w_rd_in_range
                         && (32'(i_read_col) < 32'(stb_pkg::LINE_WIDTH))
                         && (32'(i_read_col) < 32'(w_rd_len));
    assign w_raddr       = ADDR_W'(w_rd_phys) * ADDR_W'(stb_pkg::LINE_WIDTH)
                         + ADDR_W'(i_read_col);

    always_comb begin
        n_top       = r_top;
        n_line      = r_line;
        n_cur_phys  = r_cur_phys;
        n_col       = r_col;
        n_hit       = r_hit;
        w_col_pos   = r_col;
        w_len_we    = 1'b0;
        w_len_wdata = '0;
        w_clear_all = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        if (i_cmd.exec) begin
            n_hit = 1'b0;
            case (stb_pkg::t_op'(i_op))
                stb_pkg::OP_PUT: begin
                    if (!w_is_cr && (w_is_lf || w_wrap)) begin
                        n_col = '0;
                        if (r_line < ROW_W'(stb_pkg::LINE_COUNT - 1)) begin
                            n_line     = r_line + 1'b1;
                            n_cur_phys = stb_pkg::next_row(r_cur_phys);
                        end else begin
                            // old top row becomes the empty bottom row
                            n_top      = stb_pkg::next_row(r_top);
                            n_cur_phys = r_top;
                            w_len_we   = 1'b1;
                        end
                    end
                    if (!w_is_cr && !w_is_lf) begin
                        w_col_pos   = w_wrap ? '0 : r_col;
                        n_col       = w_col_pos + 1'b1;
                        w_ram_we    = 1'b1;
                        w_len_we    = 1'b1;
                        w_len_wdata = w_col_pos + 1'b1;
                    end
                end
                stb_pkg::OP_READ: begin
                    w_ram_re = 1'b1;
                    n_hit    = w_rd_hit;
                end
                stb_pkg::OP_CLEAR: begin
                    n_top       = '0;
                    n_line      = '0;
                    n_cur_phys  = '0;
                    n_col       = '0;
                    w_clear_all = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_waddr = ADDR_W'(n_cur_phys) * ADDR_W'(stb_pkg::LINE_WIDTH) + ADDR_W'(w_col_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top      <= '0;
            r_line     <= '0;
            r_cur_phys <= '0;
            r_col      <= '0;
            r_hit      <= 1'b0;
            for (int i = 0; i < stb_pkg::LINE_COUNT; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            r_top      <= n_top;
            r_line     <= n_line;
            r_cur_phys <= n_cur_phys;
            r_col      <= n_col;
            r_hit      <= n_hit;
            if (w_clear_all) begin
                for (int i = 0; i < stb_pkg::LINE_COUNT; i++) begin
                    r_len[i] <= '0;
                end
            end else if (w_len_we) begin
                r_len[n_cur_phys] <= w_len_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cell_char  <= r_hit ? w_ram_q : '0;
            r_cursor_row <= 4'(r_line);
            r_cursor_col <= 6'(r_col);
        end
    end

    stb_ram #(
        .WIDTH (7),
        .DEPTH (stb_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_glyph),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    assign o_cell_char  = r_cell_char;
    assign o_cursor_row = r_cursor_row;
    assign o_cursor_col = r_cursor_col;

endmodule
`default_nettype wire

FILE: hdl/scrolling_text_terminal_buffer_top.sv
`default_nettype none
// Timing: an answer passes the registered read of the character store, then
//   is loaded, waiting while an earlier result is held by a stalled output.
// Items: a new item is taken only once the last result is loaded, after the
//   registered store read and the load of the result register.
// Reset (synchronous, active low): clears cursor, scroll pointer and row
//   lengths at once; the character store is not cleared and needs no pass.
// ---------------------------------------------------------------------------
// scrolling_text_terminal_buffer_top
// Scrolling character terminal store: put, read and clear items, each one
// answered with the read cell and the cursor.
// ---------------------------------------------------------------------------
module scrolling_text_terminal_buffer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_char_code,
    input  logic [3:0] i_read_row,
    input  logic [4:0] i_read_col,
    // result output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_cell_char,
    output logic [3:0] o_cursor_row,
    output logic [5:0] o_cursor_col
);

    // Commands from the controller. The datapath acts on an item in the cycle
    // of its transfer (store write, length update, cursor move, or the store
    // read for a read item) and loads the result register from the LOOK state,
    // once the output register is empty or its result is being taken.
    stb_pkg::t_ctl_cmd w_cmd;

    stb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // The view scrolls by advancing a circular top-row pointer; the freed
    // row gets length zero, so no characters move in the store.
    stb_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_cell_char  (o_cell_char),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

endmodule
`default_nettype wire

FILE: hdl/stb_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stb_checker
// Port-level checks of the terminal buffer, bound to the top level.
// ---------------------------------------------------------------------------
module stb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [6:0] o_cell_char,
    input logic [3:0] o_cursor_row,
    input logic [5:0] o_cursor_col
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cell_char)
            && $stable(o_cursor_row) && $stable(o_cursor_col))
        else $error("stalled result changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transfer taken while an item is in work");

    a_cell_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cell_char == 7'd0
            || (o_cell_char >= 7'd32 && o_cell_char <= 7'd126))
        else $error("cell character outside printable set");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_cursor_col) <= 32'(stb_pkg::LINE_WIDTH))
        else $error("cursor column past line width");

endmodule

bind scrolling_text_terminal_buffer_top stb_checker u_stb_checker (.*);
`default_nettype wire

FILE: tb/tb_scrolling_text_terminal_buffer_top.sv
// ---------------------------------------------------------------------------
// tb_scrolling_text_terminal_buffer_top
// Self-checking bench for the scrolling text terminal buffer. A scoreboard
// keeps its own copy of the screen: line lengths, top-line pointer and
// cursor. From every put, read and clear transfer it predicts the returned
// character and cursor, and compares them with each result transfer. A
// short directed run is followed by random lines of text, read bursts, runs
// of line feeds and noise, under three sender/receiver idle profiles.
// ---------------------------------------------------------------------------
module tb_scrolling_text_terminal_buffer_top;

    // op code 3 is not decoded by the block; it only reports the cursor
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // full ranges of the read address fields; the row field is wider than the screen
    localparam int ROW_FIELD_MAX = 15;
    localparam int COL_FIELD_MAX = 31;

    localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer
    localparam int SETTLE_CYCLES = 8;     // wait after draining for a late or extra result

    // one predicted answer: character at the read cell plus the cursor
    typedef struct packed {
        logic [6:0] glyph;
        logic [3:0] row;
        logic [5:0] col;
    } t_cursor_report;

    // -----------------------------------------------------------------------
    // Screen scoreboard
    // -----------------------------------------------------------------------
    class terminal_screen_board;
        logic [6:0]     glyphs [stb_pkg::DEPTH];
        int unsigned    line_len [stb_pkg::LINE_COUNT];
        int unsigned    top_line;
        int unsigned    cur_line;
        int unsigned    cur_col;
        t_cursor_report awaited [$];
        int unsigned    errors;
        int unsigned    taken;
        int unsigned    matched;
        int unsigned    char_reads;
        int unsigned    scrolls;
        int unsigned    clears;

        function new();
            foreach (glyphs[i]) glyphs[i] = '0;
            wipe();
            errors     = 0;
            taken      = 0;
            matched    = 0;
            char_reads = 0;
            scrolls    = 0;
            clears     = 0;
        endfunction

        function void wipe();
            foreach (line_len[i]) line_len[i] = 0;
            top_line = 0;
            cur_line = 0;
            cur_col  = 0;
        endfunction

        // Move to a new line; at the bottom, recycle the top line as an
        // empty bottom line.
        function void new_line();
            cur_col = 0;
            if (cur_line < stb_pkg::LINE_COUNT - 1) begin
                cur_line++;
            end else begin
                line_len[top_line] = 0;
                top_line = (top_line + 1) % stb_pkg::LINE_COUNT;
                scrolls++;
            end
        endfunction

        function void put_char(logic [7:0] code);
            logic [6:0]  glyph;
            int unsigned p;
            if (code == stb_pkg::CH_CR) return;
            if (code == stb_pkg::CH_LF) begin
                new_line();
                return;
            end
            glyph = (code < stb_pkg::CH_LOW || code > stb_pkg::CH_HIGH)
                  ? stb_pkg::CH_SPACE : code[6:0];
            if (cur_col >= stb_pkg::LINE_WIDTH) new_line();
            p = (top_line + cur_line) % stb_pkg::LINE_COUNT;
            glyphs[p * stb_pkg::LINE_WIDTH + cur_col] = glyph;
            cur_col++;
            line_len[p] = cur_col;
        endfunction

        // Note one accepted input transfer and queue its predicted answer.
        function void apply_item(logic [1:0] op, logic [7:0] code,
                                 logic [3:0] row, logic [4:0] col);
            t_cursor_report res;
            int unsigned    p;
            res.glyph = '0;
            taken++;
            case (op)
                stb_pkg::OP_PUT: put_char(code);
                stb_pkg::OP_READ: begin
                    if (row < stb_pkg::LINE_COUNT) begin
                        p = (top_line + row) % stb_pkg::LINE_COUNT;
                        if (col < line_len[p] && col < stb_pkg::LINE_WIDTH)
                            res.glyph = glyphs[p * stb_pkg::LINE_WIDTH + col];
                    end
                    if (res.glyph != 0) char_reads++;
                end
                stb_pkg::OP_CLEAR: begin
                    wipe();
                    clears++;
                end
                default: ;
            endcase
            res.row = 4'(cur_line);
            res.col = 6'(cur_col);
            awaited.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        // Compare one accepted result transfer with the oldest prediction.
        task match_result(logic [6:0] glyph, logic [3:0] row, logic [5:0] col);
            t_cursor_report want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected result: char %0d row %0d col %0d",
                                          glyph, row, col));
                return;
            end
            want = awaited.pop_front();
            matched++;
            if (glyph !== want.glyph)
                report_mismatch($sformatf("result %0d: cell_char %0d, predicted %0d",
                                          matched, glyph, want.glyph));
            if (row !== want.row)
                report_mismatch($sformatf("result %0d: cursor_row %0d, predicted %0d",
                                          matched, row, want.row));
            if (col !== want.col)
                report_mismatch($sformatf("result %0d: cursor_col %0d, predicted %0d",
                                          matched, col, want.col));
        endtask

        function int pending();
            return awaited.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Clock, reset and DUT
    // -----------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_op        = stb_pkg::OP_PUT;
    logic [7:0] i_char_code = '0;
    logic [3:0] i_read_row  = '0;
    logic [4:0] i_read_col  = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [6:0] o_cell_char;
    logic [3:0] o_cursor_row;
    logic [5:0] o_cursor_col;

    terminal_screen_board board;

    int unsigned in_idle_pct   = 0;   // chance per item of a sender gap
    int unsigned out_stall_pct = 0;   // chance per cycle of a receiver stall
    int unsigned items_sent    = 0;   // transfers that change or read state
    int unsigned quiet_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    scrolling_text_terminal_buffer_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_char  (o_cell_char),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

    // -----------------------------------------------------------------------
    // Monitor: sample both channels at the edge, record input transfers
    // before checking results, then pick the next receiver stall.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                board.apply_item(i_op, i_char_code, i_read_row, i_read_col);
            if (o_out_valid && !i_out_stall)
                board.match_result(o_cell_char, o_cursor_row, o_cursor_col);
        end
        i_out_stall <= i_rst_n && ($urandom_range(99) < out_stall_pct);
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Watchdog: no transfer in %0d cycles", QUIET_LIMIT);
            $display("tb_scrolling_text_terminal_buffer_top failed");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------

    // Present one item, hold it while stalled, return at its transfer edge.
    // Keep valid high between back-to-back items; drop it only for a gap.
    task automatic send_item(logic [1:0] op, logic [7:0] code,
                             logic [3:0] row, logic [4:0] col);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_char_code <= code;
        i_read_row  <= row;
        i_read_col  <= col;
        do @(posedge i_clk); while (o_in_stall);
        // skip items the block ignores when counting stimulus
        if (!(op == OP_UNUSED || (op == stb_pkg::OP_PUT && code == stb_pkg::CH_CR)))
            items_sent++;
    endtask

    // Put a byte; fill the unused read fields with noise.
    task automatic put_byte(logic [7:0] code);
        send_item(stb_pkg::OP_PUT, code, 4'($urandom_range(ROW_FIELD_MAX)),
                  5'($urandom_range(COL_FIELD_MAX)));
    endtask

    task automatic read_cell(logic [3:0] row, logic [4:0] col);
        send_item(stb_pkg::OP_READ, 8'($urandom_range(255)), row, col);
    endtask

    task automatic clear_screen();
        send_item(stb_pkg::OP_CLEAR, 8'($urandom_range(255)),
                  4'($urandom_range(ROW_FIELD_MAX)),
                  5'($urandom_range(COL_FIELD_MAX)));
    endtask

    // Hold the sender off until every predicted result has come back.
    // Pass a clock edge before the first check so the last transfer is on the books.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Mostly printable text, now and then any byte at all.
    function automatic logic [7:0] pick_text_byte();
        if ($urandom_range(9) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(stb_pkg::CH_LOW, stb_pkg::CH_HIGH));
    endfunction

    // Mostly visible rows, sometimes rows past the bottom.
    function automatic logic [3:0] pick_row();
        if ($urandom_range(7) == 0)
            return 4'($urandom_range(stb_pkg::LINE_COUNT, ROW_FIELD_MAX));
        return 4'($urandom_range(stb_pkg::LINE_COUNT - 1));
    endfunction

    // Favor the left half of the row, where text usually is.
    function automatic logic [4:0] pick_col();
        if ($urandom_range(1) == 0) return 5'($urandom_range(15));
        return 5'($urandom_range(COL_FIELD_MAX));
    endfunction

    // One random burst: text lines dominate so the cursor walks down the
    // screen, wraps and scrolls; reads probe what is there; the rest is
    // noise and the odd clear.
    task automatic random_burst();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(99);
        if (kind < 52) begin
            // a line of text, now and then at or past full width so it fills or wraps
            n = ($urandom_range(7) == 0)
              ? $urandom_range(stb_pkg::LINE_WIDTH, stb_pkg::LINE_WIDTH + 12)
              : $urandom_range(20);
            repeat (n) put_byte(pick_text_byte());
            case ($urandom_range(7))
                0: ;  // leave the line open for the next burst
                1: begin
                    put_byte(stb_pkg::CH_CR);
                    put_byte(stb_pkg::CH_LF);
                end
                default: put_byte(stb_pkg::CH_LF);
            endcase
        end else if (kind < 80) begin
            repeat ($urandom_range(1, 4)) read_cell(pick_row(), pick_col());
        end else if (kind < 86) begin
            // run of blank lines to push the view into scrolling
            repeat ($urandom_range(1, 12)) put_byte(stb_pkg::CH_LF);
        end else if (kind < 99) begin
            case ($urandom_range(2))
                0: put_byte(8'($urandom_range(255)));
                1: read_cell(4'($urandom_range(ROW_FIELD_MAX)),
                             5'($urandom_range(COL_FIELD_MAX)));
                default: send_item(OP_UNUSED, 8'($urandom_range(255)),
                                   4'($urandom_range(ROW_FIELD_MAX)),
                                   5'($urandom_range(COL_FIELD_MAX)));
            endcase
        end else begin
            clear_screen();
        end
    endtask

    task automatic random_until(int unsigned target);
        while (items_sent < target) random_burst();
    endtask

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial begin
        board = new();

        // hold reset, then release it once
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first profile: rare sender gaps, frequent receiver stalls
        in_idle_pct   = 9;
        out_stall_pct = 53;

        // directed: empty screen, character extremes, control bytes
        read_cell(4'd0, 5'd0);
        put_byte(8'd72);
        put_byte(stb_pkg::CH_HIGH);
        put_byte(stb_pkg::CH_LOW);
        put_byte(8'd31);           // control byte becomes a space
        put_byte(8'd127);          // just above printable range
        put_byte(8'd255);
        put_byte(8'd0);
        put_byte(stb_pkg::CH_CR);  // ignored
        read_cell(4'd0, 5'd0);
        read_cell(4'd0, 5'd6);     // last written cell
        read_cell(4'd0, 5'd7);     // just past the line end
        read_cell(4'd15, 5'd31);   // row beyond the screen
        put_byte(stb_pkg::CH_LF);
        put_byte(8'd120);
        read_cell(4'd1, 5'd0);
        read_cell(4'd9, 5'd0);     // empty bottom row
        send_item(OP_UNUSED, 8'hFF, 4'hF, 5'h1F);
        clear_screen();
        read_cell(4'd0, 5'd0);     // stale data behind a zero length
        put_byte(stb_pkg::CH_LF);
        put_byte(8'd65);
        read_cell(4'd1, 5'd0);

        random_until(200);
        wait_for_results();

        // second profile: frequent sender gaps, rare receiver stalls
        in_idle_pct   = 53;
        out_stall_pct = 9;
        random_until(380);
        wait_for_results();

        // last profile: full rate on both sides
        in_idle_pct   = 0;
        out_stall_pct = 0;
        random_until(540);

        // drain, then give a late or extra result time to show up
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d results never arrived", board.pending()));

        $display("Summary: %0d items accepted, %0d results checked, three idle profiles",
                 board.taken, board.matched);
        $display("Summary: %0d reads returned a character, %0d scrolls, %0d clears",
                 board.char_reads, board.scrolls, board.clears);
        if (board.errors == 0) begin
            $display("tb_scrolling_text_terminal_buffer_top passed");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("tb_scrolling_text_terminal_buffer_top failed");
        end
        $finish;
    end

endmodule
